/* rtl/core/lct_pkg.sv */
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the LCD text cursor terminal.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Cursor and payload widths
  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int GCOL_W  = 3;
  localparam int STEP_W  = 4;

  // Depth of the job queue between front and back end
  localparam int JOB_QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h7F;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // LCD address command prefixes
  localparam logic [BYTE_W-1:0] CMD_SET_X = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_SET_Y = 8'h40;

  // Back-end step codes ahead of the data slots
  localparam logic [STEP_W-1:0] STEP_SET_X = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SET_Y = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DATA0 = 4'd2;

  // One draw job: glyph and the cell it goes to
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } job_t;

endpackage

/* rtl/core/lcd_text_cursor_terminal.sv */
// Path: a taken character passes the job queue and the back-end job register into the
//   output register. Throughput: one result beat per cycle while out_pop keeps up;
//   a drawn character or backspace yields set-X, set-Y, GLYPH_WIDTH data beats; a newline none.
// Reset (synchronous, rst_n low): flip mode set, cursor at the last row and column,
//   job queue and output register empty.
// ----------------------------------------------------------------------------
// lcd_text_cursor_terminal
// Character terminal front end: cursor tracking and LCD byte stream generation.
// ----------------------------------------------------------------------------
module lcd_text_cursor_terminal #(
  parameter int TEXT_ROWS   = 6,
  parameter int TEXT_COLS   = 14,
  parameter int GLYPH_WIDTH = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_push,
  input  logic [lct_pkg::CHAR_W-1:0] in_character,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_is_data,
  output logic [lct_pkg::BYTE_W-1:0] out_command_byte,
  output logic [lct_pkg::CHAR_W-1:0] out_glyph_code,
  output logic [lct_pkg::GCOL_W-1:0] out_glyph_column,
  output logic                       out_last
);
  import lct_pkg::*;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_wr, job_rd;

  // Front end: classify and track cursor
  lct_front #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (in_push),
    .in_character (in_character),
    .in_full      (in_full),
    .job_push     (job_push),
    .job_data     (job_wr),
    .job_full     (job_full)
  );

  // Decoupling queue
  lct_job_fifo #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  // Back end: byte stream expansion
  lct_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_data         (job_rd),
    .job_empty        (job_empty),
    .job_pop          (job_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_is_data      (out_is_data),
    .out_command_byte (out_command_byte),
    .out_glyph_code   (out_glyph_code),
    .out_glyph_column (out_glyph_column),
    .out_last         (out_last)
  );

endmodule

/* rtl/core/lct_front.sv */
// ----------------------------------------------------------------------------
// lct_front
// Accepts characters, keeps the text cursor and queues draw jobs.
// ----------------------------------------------------------------------------
module lct_front #(
  parameter int TEXT_ROWS = 6,
  parameter int TEXT_COLS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_push,
  input  logic [lct_pkg::CHAR_W-1:0] in_character,
  output logic                       in_full,
  output logic                       job_push,
  output lct_pkg::job_t              job_data,
  input  logic                       job_full
);
  import lct_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TEXT_COLS - 1);

  logic             flip_r, flip_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic                       accept;
  logic                       is_bs, is_nl;
  logic [ROW_W+COL_W-1:0]     pos_fwd, pos_back;

  // Cyclic row step, up or down
  function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] row,
                                                input logic up);
    logic [ROW_W-1:0] res;
    if (up) begin
      res = (row == ROW_LAST) ? '0 : row + ROW_W'(1);
    end else begin
      res = (row == '0) ? ROW_LAST : row - ROW_W'(1);
    end
    return res;
  endfunction

  // Column step with wrap into the next row; returns {row, col}
  function automatic logic [ROW_W+COL_W-1:0] col_step(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col,
                                                      input logic up);
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    r = row;
    if (up) begin
      if (col == COL_LAST) begin
        c = '0;
        r = row_step(row, up);
      end else begin
        c = col + COL_W'(1);
      end
    end else begin
      if (col == '0) begin
        c = COL_LAST;
        r = row_step(row, up);
      end else begin
        c = col - COL_W'(1);
      end
    end
    return {r, c};
  endfunction

  // Classify the incoming beat
  assign in_full = job_full;
  assign accept  = in_push && !job_full;
  assign is_bs   = (in_character == CHAR_BS);
  assign is_nl   = (in_character == CHAR_CR) || (in_character == CHAR_LF);

  // Forward is "up" unless flipped; backspace runs the other way
  assign pos_fwd  = col_step(row_r, col_r, !flip_r);
  assign pos_back = col_step(row_r, col_r, flip_r);

  // Cursor update and job generation
  always_comb begin
    flip_nxt = flip_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    job_push = 1'b0;
    job_data = '{code: in_character, row: row_r, col: col_r};
    if (cfg_wr_en) begin
      flip_nxt = cfg_wr_data;
      row_nxt  = cfg_wr_data ? ROW_LAST : '0;
      col_nxt  = cfg_wr_data ? COL_LAST : '0;
    end else if (accept) begin
      if (is_bs) begin
        job_push = 1'b1;
        job_data = '{code: CHAR_SPACE, row: pos_back[COL_W +: ROW_W],
                     col: pos_back[COL_W-1:0]};
        row_nxt  = pos_back[COL_W +: ROW_W];
        col_nxt  = pos_back[COL_W-1:0];
      end else if (is_nl) begin
        row_nxt = row_step(row_r, !flip_r);
        col_nxt = flip_r ? COL_LAST : '0;
      end else begin
        job_push = 1'b1;
        row_nxt  = pos_fwd[COL_W +: ROW_W];
        col_nxt  = pos_fwd[COL_W-1:0];
      end
    end
  end

  // State registers; flipped at reset, cursor at the flipped home
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r <= 1'b1;
      row_r  <= ROW_LAST;
      col_r  <= COL_LAST;
    end else begin
      flip_r <= flip_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

/* rtl/core/lct_job_fifo.sv */
// ----------------------------------------------------------------------------
// lct_job_fifo
// Short register queue of draw jobs between front and back end.
// ----------------------------------------------------------------------------
module lct_job_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  lct_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lct_pkg::job_t rd_data,
  output logic          empty
);
  import lct_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/lct_back.sv */
// ----------------------------------------------------------------------------
// lct_back
// Expands each draw job into address commands and font data slots.
// ----------------------------------------------------------------------------
module lct_back #(
  parameter int GLYPH_WIDTH = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lct_pkg::job_t              job_data,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_is_data,
  output logic [lct_pkg::BYTE_W-1:0] out_command_byte,
  output logic [lct_pkg::CHAR_W-1:0] out_glyph_code,
  output logic [lct_pkg::GCOL_W-1:0] out_glyph_column,
  output logic                       out_last
);
  import lct_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GLYPH_WIDTH + 1);

  job_t              job_r, job_nxt;
  logic              job_valid_r, job_valid_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              is_data_r, is_data_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [CHAR_W-1:0] code_r, code_nxt;
  logic [GCOL_W-1:0] gcol_r, gcol_nxt;
  logic              last_r, last_nxt;

  logic emit, pop_ok, step_is_last, job_load;

  // Handshake bookkeeping
  assign pop_ok       = out_pop && out_valid_r;
  assign emit         = job_valid_r && (!out_valid_r || out_pop);
  assign step_is_last = (step_r == STEP_LAST);
  assign job_load     = !job_valid_r || (emit && step_is_last);
  assign job_pop      = job_load && !job_empty;

  // Job register and step counter
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    step_nxt      = step_r;
    if (job_load) begin
      job_nxt       = job_data;
      job_valid_nxt = !job_empty;
      step_nxt      = STEP_SET_X;
    end else if (emit) begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // Result beat for the current step
  always_comb begin
    out_valid_nxt = out_valid_r;
    is_data_nxt   = is_data_r;
    cmd_nxt       = cmd_r;
    code_nxt      = code_r;
    gcol_nxt      = gcol_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      last_nxt      = step_is_last;
      case (step_r)
        STEP_SET_X: begin
          is_data_nxt = 1'b0;
          cmd_nxt     = CMD_SET_X | BYTE_W'(job_r.col * GLYPH_WIDTH);
          code_nxt    = '0;
          gcol_nxt    = '0;
        end
        STEP_SET_Y: begin
          is_data_nxt = 1'b0;
          cmd_nxt     = CMD_SET_Y | BYTE_W'(job_r.row);
          code_nxt    = '0;
          gcol_nxt    = '0;
        end
        default: begin
          is_data_nxt = 1'b1;
          cmd_nxt     = '0;
          code_nxt    = job_r.code;
          gcol_nxt    = GCOL_W'(step_r - STEP_DATA0);
        end
      endcase
    end else if (pop_ok) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_SET_X;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    is_data_r <= is_data_nxt;
    cmd_r     <= cmd_nxt;
    code_r    <= code_nxt;
    gcol_r    <= gcol_nxt;
    last_r    <= last_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_is_data      = is_data_r;
  assign out_command_byte = cmd_r;
  assign out_glyph_code   = code_r;
  assign out_glyph_column = gcol_r;
  assign out_last         = last_r;

endmodule
